FILE: hw/rtl/mqp_pkg.sv
// ----------------------------------------------------------------------------
// mqp_pkg: shared constants for the min queue with position
// Default sizes, operation codes and status codes of the result word.
// ----------------------------------------------------------------------------
package mqp_pkg;

  // default sizes
  localparam int DEFAULT_DEPTH     = 1024;
  localparam int DEFAULT_DATA_BITS = 32;

  // width of the value field on the input stream
  localparam int VALUE_FIELD_BITS = 32;

  // operation selected by the tuser bit
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  // status codes of a result word
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

FILE: hw/rtl/min_queue_with_position.sv
// ----------------------------------------------------------------------------
// min_queue_with_position: fifo that reports its minimum and its position
// Item ring plus a strictly increasing ring of candidate minima, each tagged
// with its push sequence number.
// ----------------------------------------------------------------------------
// Each input word (tuser bit 0: 0 enqueue, 1 dequeue; tdata: value) produces
// exactly one result word. The block works on one word at a time through a
// small sequencer around the candidate ram, whose single read port sets the
// pace: a dequeue passes through a read, a check and a head read; an enqueue
// reads and compares each candidate examined at the tail, then writes the new
// candidate and reads the head (every candidate is dropped at most once). A
// rejected operation (enqueue on full, dequeue on empty) only reads the head. A
// new word is accepted while the previous result still waits in the output
// register. There is no clearing pass after reset; only data read from written
// entries is used.
// ----------------------------------------------------------------------------
module min_queue_with_position
  import mqp_pkg::*;
#(
  parameter int DEPTH     = DEFAULT_DEPTH,
  parameter int DATA_BITS = DEFAULT_DATA_BITS,
  localparam int IN_W     = ((DATA_BITS + 7) / 8) * 8,
  localparam int AW       = $clog2(DEPTH),
  localparam int CW       = $clog2(DEPTH + 1),
  localparam int OUT_RAW  = 2 * DATA_BITS + 2 * CW + AW + 3,
  localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // input stream
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // value
  input  logic             s_tuser,   // mode
  // result stream
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // removed_value, queue_count, candidate_count,
                                      // min_value, min_offset, min_valid, status
);

  localparam int SW = $clog2(2 * DEPTH);
  localparam int VB = (DATA_BITS < VALUE_FIELD_BITS) ? DATA_BITS : VALUE_FIELD_BITS;
  localparam int CAND_W = DATA_BITS + SW;
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [SW-1:0] LAST_SEQ = SW'(2 * DEPTH - 1);
  localparam logic [SW:0]   SEQ_MOD  = (SW + 1)'(2 * DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_RD,
    S_ENQ_CMP,
    S_ENQ_WR,
    S_DEQ_RD,
    S_DEQ_CHK,
    S_HEAD_RD,
    S_FIN
  } state_t;

  state_t                state;
  logic [AW-1:0]         item_head;
  logic [AW-1:0]         item_tail;
  logic [CW-1:0]         item_total;
  logic [AW-1:0]         cand_head;
  logic [AW-1:0]         cand_tail;
  logic [CW-1:0]         cand_total;
  logic [SW-1:0]         push_seq;
  logic [SW-1:0]         pop_seq;
  logic [DATA_BITS-1:0]  op_value;
  logic [DATA_BITS-1:0]  removed;
  logic [1:0]            status;

  logic                  item_we;
  logic [AW-1:0]         item_raddr;
  logic [DATA_BITS-1:0]  item_rdata;
  logic                  cand_we;
  logic [AW-1:0]         cand_raddr;
  logic [CAND_W-1:0]     cand_rdata;
  logic [DATA_BITS-1:0]  cand_rd_value;
  logic [SW-1:0]         cand_rd_seq;
  logic [AW-1:0]         cand_tail_prev;
  logic                  in_fire;
  logic                  out_free;
  logic [SW:0]           seq_diff;
  logic [SW:0]           seq_off;
  logic                  res_valid;
  logic [DATA_BITS-1:0]  res_min;
  logic [AW-1:0]         res_off;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST_PTR : p - 1'b1;
  endfunction

  function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] s);
    return (s == LAST_SEQ) ? '0 : s + 1'b1;
  endfunction

  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign cand_rd_value  = cand_rdata[DATA_BITS-1:0];
  assign cand_rd_seq    = cand_rdata[CAND_W-1:DATA_BITS];
  assign cand_tail_prev = ptr_dec(cand_tail);

  // item write happens in the accept cycle of a non-full enqueue
  assign item_we    = in_fire && (s_tuser == MODE_ENQ) && (item_total != FULL_CNT);
  assign item_raddr = item_head;
  assign cand_we    = (state == S_ENQ_WR);

  // candidate read address: tail while dropping, head otherwise
  always_comb begin
    case (state)
      S_ENQ_RD: cand_raddr = cand_tail_prev;
      default:  cand_raddr = cand_head;
    endcase
  end

  // minimum and its distance from the head, from the head candidate
  assign seq_diff  = {1'b0, cand_rd_seq} - {1'b0, pop_seq};
  assign seq_off   = seq_diff[SW] ? seq_diff + SEQ_MOD : seq_diff;
  assign res_valid = (item_total != '0) && (cand_total != '0);
  assign res_min   = res_valid ? cand_rd_value : '0;
  assign res_off   = res_valid ? seq_off[AW-1:0] : '0;

  mqp_ram #(
    .DEPTH (DEPTH),
    .WIDTH (DATA_BITS)
  ) u_item_ram (
    .clk   (clk),
    .we    (item_we),
    .waddr (item_tail),
    .wdata (DATA_BITS'(s_tdata[VB-1:0])),
    .raddr (item_raddr),
    .rdata (item_rdata)
  );

  mqp_ram #(
    .DEPTH (DEPTH),
    .WIDTH (CAND_W)
  ) u_cand_ram (
    .clk   (clk),
    .we    (cand_we),
    .waddr (cand_tail),
    .wdata ({push_seq, op_value}),
    .raddr (cand_raddr),
    .rdata (cand_rdata)
  );

  // sequencer, queue pointers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      item_head  <= '0;
      item_tail  <= '0;
      item_total <= '0;
      cand_head  <= '0;
      cand_tail  <= '0;
      cand_total <= '0;
      push_seq   <= '0;
      pop_seq    <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // a word taken while no new one is presented frees the output register
      if (m_tvalid && m_tready && (state != S_FIN)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            op_value <= DATA_BITS'(s_tdata[VB-1:0]);
            removed  <= '0;
            status   <= ST_OK;
            if (s_tuser == MODE_ENQ) begin
              if (item_total == FULL_CNT) begin
                status <= ST_FULL;
                state  <= S_HEAD_RD;
              end else begin
                item_tail  <= ptr_inc(item_tail);
                item_total <= item_total + 1'b1;
                state      <= (cand_total != '0) ? S_ENQ_RD : S_ENQ_WR;
              end
            end else begin
              if (item_total == '0) begin
                status <= ST_EMPTY;
                state  <= S_HEAD_RD;
              end else begin
                state <= S_DEQ_RD;
              end
            end
          end
        end
        S_ENQ_RD: begin
          state <= S_ENQ_CMP;
        end
        S_ENQ_CMP: begin
          // drop a tail candidate that is not below the new value
          if (cand_rd_value >= op_value) begin
            cand_tail  <= cand_tail_prev;
            cand_total <= cand_total - 1'b1;
            state      <= (cand_total != CW'(1)) ? S_ENQ_RD : S_ENQ_WR;
          end else begin
            state <= S_ENQ_WR;
          end
        end
        S_ENQ_WR: begin
          cand_tail  <= ptr_inc(cand_tail);
          cand_total <= cand_total + 1'b1;
          push_seq   <= seq_inc(push_seq);
          state      <= S_HEAD_RD;
        end
        S_DEQ_RD: begin
          state <= S_DEQ_CHK;
        end
        S_DEQ_CHK: begin
          removed    <= item_rdata;
          item_head  <= ptr_inc(item_head);
          item_total <= item_total - 1'b1;
          // head candidate leaves only when it is the popped item itself
          if ((cand_total != '0) && (cand_rd_seq == pop_seq)) begin
            cand_head  <= ptr_inc(cand_head);
            cand_total <= cand_total - 1'b1;
          end
          pop_seq <= seq_inc(pop_seq);
          state   <= S_HEAD_RD;
        end
        S_HEAD_RD: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_W'({status, res_valid, res_off, res_min,
                                cand_total, item_total, removed});
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // candidate list never outgrows the queue
  a_cand_le_items: assert property (@(posedge clk) disable iff (rst)
    cand_total <= item_total)
    else $error("candidate count exceeds queue count");

  // when idle, the queue is non-empty exactly when it has a minimum candidate
  a_nonempty_has_cand: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((item_total != '0) == (cand_total != '0)))
    else $error("queue and candidate list disagree on emptiness");

  // a finished word is presented once the output register is free
  a_fin_presents: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && out_free |=> m_tvalid && (state == S_IDLE))
    else $error("finished word not presented");

endmodule

FILE: hw/rtl/mqp_ram.sv
// ----------------------------------------------------------------------------
// mqp_ram: simple dual-port ram with registered read
// One write port and one read port, read data valid the cycle after the address.
// ----------------------------------------------------------------------------
module mqp_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
